>>> src/pitched_framebuffer_blit_assert.svh
`ifndef PITCHED_FRAMEBUFFER_BLIT_ASSERT_SVH
`define PITCHED_FRAMEBUFFER_BLIT_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define PFB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequence that follows in the cycle after the trigger
`define PFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pfb_pkg.sv
package pfb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

  localparam logic [1:0] MODE_ARGB32 = 2'd0;
  localparam logic [1:0] MODE_RGB565 = 2'd1;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [15:0] line_pitch;
    logic [11:0] x_offset;
    logic [11:0] y_offset;
    logic [1:0]  pixel_mode;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  function automatic logic mode_wide(input cfg_t c);
    return c.pixel_mode == MODE_ARGB32;
  endfunction

  // a write goes out only with a nonzero base and a supported depth
  function automatic logic write_enabled(input cfg_t c);
    return (c.frame_base != 32'h0000_0000) &&
           (c.pixel_mode == MODE_ARGB32 || c.pixel_mode == MODE_RGB565);
  endfunction

endpackage

>>> src/pfb_front.sv
module pfb_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfb_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_pixel,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [31:0]                push_pixel,
  output logic [$clog2(MAX_DIM)-1:0] push_col,
  output logic [$clog2(MAX_DIM)-1:0] push_row,
  output logic                       push_last
);
  import pfb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int EXT_W = CNT_W + 1;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [EXT_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic             row_end, frame_end, accept;

  // zero acts as one, oversize acts as the maximum
  function automatic logic [EXT_W-1:0] clamp_dim(input logic [12:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      v32 = 32'd1;
    end else if (v32 > 32'(MAX_DIM)) begin
      v32 = 32'(MAX_DIM);
    end
    return EXT_W'(v32);
  endfunction

  assign w_eff     = clamp_dim(cfg.image_width);
  assign h_eff     = clamp_dim(cfg.image_height);
  assign col_inc   = EXT_W'(col_r) + EXT_W'(1);
  assign row_inc   = EXT_W'(row_r) + EXT_W'(1);
  // >= also covers counters left past a shrunk dimension
  assign row_end   = col_inc >= w_eff;
  assign frame_end = row_end && (row_inc >= h_eff);

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && write_enabled(cfg);
  assign push_pixel = in_pixel;
  assign push_col   = col_r;
  assign push_row   = row_r;
  assign push_last  = frame_end;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = CNT_W'(row_inc);
      end else begin
        col_nxt = CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> src/pfb_fifo.sv
module pfb_fifo #(
  parameter int WIDTH = 57,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  `include "pitched_framebuffer_blit_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `PFB_ASSERT_ALWAYS(a_fifo_bound, count_r <= CNT_W'(DEPTH), "queue count past depth")
  `PFB_ASSERT_NEXT(a_fifo_grow, do_push && !do_pop, count_r == $past(count_r) + 1'b1,
    "queue count did not grow on push")
  `PFB_ASSERT_NEXT(a_fifo_shrink, do_pop && !do_push, count_r == $past(count_r) - 1'b1,
    "queue count did not shrink on pop")

endmodule

>>> src/pfb_back.sv
module pfb_back #(
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfb_pkg::cfg_t              cfg,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  logic [31:0]                pop_pixel,
  input  logic [$clog2(MAX_DIM)-1:0] pop_col,
  input  logic [$clog2(MAX_DIM)-1:0] pop_row,
  input  logic                       pop_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_addr,
  output logic [31:0]                out_data,
  output logic                       out_wide,
  output logic                       out_last
);
  import pfb_pkg::*;
  `include "pitched_framebuffer_blit_assert.svh"

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int SUM_W  = ((CNT_W > 12) ? CNT_W : 12) + 1;
  localparam int PROD_W = SUM_W + 16;

  logic             wide;
  logic             s1_ready, s2_ready, out_ready_int;

  logic             s1_valid_r;
  logic [31:0]      s1_pixel_r;
  logic             s1_last_r;
  logic [SUM_W-1:0] s1_row_r, s1_col_r;

  logic             s2_valid_r;
  logic [31:0]      s2_pixel_r;
  logic             s2_last_r;
  logic [31:0]      s2_prod_r, s2_coff_r;

  logic             out_valid_r;
  logic [31:0]      out_addr_r, out_data_r;
  logic             out_wide_r, out_last_r;

  logic [PROD_W-1:0] prod;
  logic [31:0]       col_ext, coff, addr_nxt, data_nxt;

  assign wide          = mode_wide(cfg);
  assign out_ready_int = !out_valid_r || out_ready;
  assign s2_ready      = !s2_valid_r || out_ready_int;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign pop_ready     = s1_ready;

  assign prod     = PROD_W'(s1_row_r) * PROD_W'(cfg.line_pitch);
  assign col_ext  = 32'(s1_col_r);
  assign coff     = wide ? (col_ext << 2) : (col_ext << 1);
  assign addr_nxt = cfg.frame_base + s2_prod_r + s2_coff_r;
  // rgb565 by truncation, alpha dropped
  assign data_nxt = wide ? s2_pixel_r
                         : {16'h0000, s2_pixel_r[23:19], s2_pixel_r[15:10], s2_pixel_r[7:3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= pop_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_ready_int) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && s1_ready) begin
      s1_pixel_r <= pop_pixel;
      s1_last_r  <= pop_last;
      s1_row_r   <= SUM_W'(pop_row) + SUM_W'(cfg.y_offset);
      s1_col_r   <= SUM_W'(pop_col) + SUM_W'(cfg.x_offset);
    end
    if (s1_valid_r && s2_ready) begin
      s2_pixel_r <= s1_pixel_r;
      s2_last_r  <= s1_last_r;
      s2_prod_r  <= 32'(prod);
      s2_coff_r  <= coff;
    end
    if (s2_valid_r && out_ready_int) begin
      out_addr_r <= addr_nxt;
      out_data_r <= data_nxt;
      out_wide_r <= wide;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_addr  = out_addr_r;
  assign out_data  = out_data_r;
  assign out_wide  = out_wide_r;
  assign out_last  = out_last_r;

  `PFB_ASSERT_NEXT(a_pop_enters, pop_valid && pop_ready, s1_valid_r,
    "popped request lost before first stage")
  `PFB_ASSERT_NEXT(a_s2_to_out, s2_valid_r && out_ready_int, out_valid_r,
    "request lost between multiply stage and output")
  `PFB_ASSERT_ALWAYS(a_narrow_upper, !out_valid_r || out_wide_r || out_data_r[31:16] == 16'h0000,
    "two-byte write carries upper data bits")

endmodule

>>> src/pitched_framebuffer_blit.sv
// Pitched framebuffer blitter: ARGB8888 pixels in raster order become memory writes.
// Configure with cfg_wr_en/cfg_index/cfg_wdata while the block is idle: 0 frame base,
// 1 line pitch, 2 x offset, 3 y offset, 4 pixel mode (0 32 bpp, 1 rgb565), 5 width,
// 6 height. A zero base or an unsupported mode consumes pixels without writes.
// in_tdata carries one source pixel per request. Each accepted pixel yields at most one
// write on the out_ channel: address and data in out_tdata, byte size in out_tuser,
// last pixel of the frame in out_tlast. Column and row counters advance on every pixel.
// Throughput is one pixel per clock while out_tready is high; between input acceptance and
// out_tvalid come the queue write, then offset add, row times pitch multiply, address add.
// The row-by-pitch multiplier is pipelined behind its own register and sets the depth.
// A four-entry queue separates the pixel counter front from the address pipeline;
// when out_tready is low the pipeline fills, then the queue, then in_tready drops.
// Synchronous reset clears the counters, queue and pipeline, and restores the
// registers to zero with width and height of one.
module pitched_framebuffer_blit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] source_pixel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // [31:0] write_address, [63:32] write_data
  output logic                           out_tuser,  // [0] wide_write
  output logic                           out_tlast
);
  import pfb_pkg::*;

  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int Q_WIDTH = 32 + 2 * CNT_W + 1;
  localparam int Q_DEPTH = 4;

  cfg_t cfg_r, cfg_nxt;

  logic               push_valid, push_ready, push_last;
  logic [31:0]        push_pixel;
  logic [CNT_W-1:0]   push_col, push_row;
  logic [Q_WIDTH-1:0] push_data, pop_data;
  logic               pop_valid, pop_ready;
  logic [31:0]        out_addr, out_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_BASE:   cfg_nxt.frame_base   = cfg_wdata[31:0];
        REG_LINE_PITCH:   cfg_nxt.line_pitch   = cfg_wdata[15:0];
        REG_X_OFFSET:     cfg_nxt.x_offset     = cfg_wdata[11:0];
        REG_Y_OFFSET:     cfg_nxt.y_offset     = cfg_wdata[11:0];
        REG_PIXEL_MODE:   cfg_nxt.pixel_mode   = cfg_wdata[1:0];
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_wdata[12:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_base   <= '0;
      cfg_r.line_pitch   <= '0;
      cfg_r.x_offset     <= '0;
      cfg_r.y_offset     <= '0;
      cfg_r.pixel_mode   <= MODE_ARGB32;
      cfg_r.image_width  <= 13'd1;
      cfg_r.image_height <= 13'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pfb_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pixel   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pixel (push_pixel),
    .push_col   (push_col),
    .push_row   (push_row),
    .push_last  (push_last)
  );

  assign push_data = {push_pixel, push_row, push_col, push_last};

  pfb_fifo #(.WIDTH(Q_WIDTH), .DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pfb_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_pixel (pop_data[Q_WIDTH-1 -: 32]),
    .pop_row   (pop_data[2*CNT_W -: CNT_W]),
    .pop_col   (pop_data[CNT_W -: CNT_W]),
    .pop_last  (pop_data[0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (out_addr),
    .out_data  (out_data),
    .out_wide  (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_data, out_addr};

endmodule
